// ===== rtl/slcp_pkg.sv =====
// Shared types and constants for the sound-log command parser.
package slcp_pkg;

   localparam int SLOT_W       = 6;
   localparam int ADDR_W       = 9;
   localparam int WAIT_W       = 32;
   localparam int MASK_W       = 16;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int DEVICE_SLOTS_DEFAULT = 16;

   // Result queue depth; must be a power of two.
   localparam int OUT_DEPTH    = 8;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_WAIT  = 2'd1;
   localparam logic [1:0] KIND_LOOP  = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [7:0] BYTE_WAIT_SYNC   = 8'hFF;
   localparam logic [7:0] BYTE_WAIT_VARINT = 8'hFE;
   localparam logic [7:0] BYTE_LOOP        = 8'hFD;
   localparam logic [6:0] GROUP_MASK       = 7'h7F;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ENABLE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_PRESENT  = 4'd1;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] device_slot;
      logic [ADDR_W-1:0] reg_address;
      logic [7:0]        reg_data;
      logic [WAIT_W-1:0] wait_syncs;
      logic              last;
   } result_type;

   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } parse_out_type;

endpackage

// ===== rtl/slcp_parser.sv =====
// Command parser state and per-byte result generation.
module slcp_parser #(
   parameter int DEVICE_SLOTS = slcp_pkg::DEVICE_SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_valid,
   input  logic [7:0]                  stream_byte,
   input  logic [slcp_pkg::MASK_W-1:0] device_enable_mask,
   input  logic                        loop_present,
   output slcp_pkg::parse_out_type     parse_out
);
   import slcp_pkg::*;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_REG     = 3'd1;
   localparam logic [2:0] PH_DATA    = 3'd2;
   localparam logic [2:0] PH_VARINT  = 3'd3;
   localparam logic [2:0] PH_WAITING = 3'd4;
   localparam logic [2:0] PH_ENDED   = 3'd5;

   localparam logic [5:0] SHIFT_STEP = 6'd7;
   localparam logic [5:0] SHIFT_MAX  = 6'd35;
   localparam logic [5:0] SHIFT_LIM  = 6'd32;

   logic [2:0]        phase_ff, phase_in;
   logic [7:0]        command_ff, command_in;
   logic [7:0]        register_ff, register_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [WAIT_W-1:0] varint_ff, varint_in;
   logic [5:0]        shift_ff, shift_in;

   logic [WAIT_W+6:0] group_shifted;
   logic [SLOT_W-1:0] slot;
   logic              slot_enabled;
   logic              pending;
   result_type        wait_res;
   result_type        cmd_res;

   assign slot = command_ff[6:1];
   assign slot_enabled = ({1'b0, slot} < 7'(DEVICE_SLOTS)) && (slot < 6'(MASK_W))
                         && device_enable_mask[slot[3:0]];
   assign group_shifted = (39'(stream_byte & {1'b0, GROUP_MASK})) << shift_ff[4:0];

   always_comb begin
      phase_in    = phase_ff;
      command_in  = command_ff;
      register_in = register_ff;
      wait_in     = wait_ff;
      varint_in   = varint_ff;
      shift_in    = shift_ff;
      parse_out   = '0;
      pending     = (phase_ff == PH_WAITING);
      wait_res    = '0;
      wait_res.kind       = KIND_WAIT;
      wait_res.wait_syncs = wait_ff;
      cmd_res     = '0;
      cmd_res.last = 1'b1;
      cmd_res.kind = (stream_byte == BYTE_LOOP && loop_present) ? KIND_LOOP : KIND_END;
      if (byte_valid) begin
         case (phase_ff)
            PH_ENDED: begin
            end
            PH_REG: begin
               register_in = stream_byte;
               phase_in    = PH_DATA;
            end
            PH_DATA: begin
               phase_in = PH_IDLE;
               if (slot_enabled) begin
                  parse_out.push0            = 1'b1;
                  parse_out.res0.kind        = KIND_WRITE;
                  parse_out.res0.device_slot = slot;
                  parse_out.res0.reg_address = {command_ff[0], register_ff};
                  parse_out.res0.reg_data    = stream_byte;
                  parse_out.res0.last        = 1'b1;
               end
            end
            PH_VARINT: begin
               if (shift_ff < SHIFT_LIM) begin
                  varint_in = varint_ff | group_shifted[WAIT_W-1:0];
               end
               if (shift_ff < SHIFT_MAX) begin
                  shift_in = shift_ff + SHIFT_STEP;
               end
               if (!stream_byte[7]) begin
                  wait_in  = wait_ff + varint_in + 32'd2;
                  phase_in = PH_WAITING;
               end
            end
            PH_IDLE, PH_WAITING: begin
               if (stream_byte == BYTE_WAIT_SYNC) begin
                  wait_in  = wait_ff + 32'd1;
                  phase_in = PH_WAITING;
               end else if (stream_byte == BYTE_WAIT_VARINT) begin
                  varint_in = '0;
                  shift_in  = '0;
                  phase_in  = PH_VARINT;
               end else begin
                  if (pending) begin
                     wait_in = '0;
                  end
                  if (!stream_byte[7]) begin
                     // A register write opens; only a pending wait is reported now.
                     command_in = stream_byte;
                     phase_in   = PH_REG;
                     if (pending) begin
                        parse_out.push0     = 1'b1;
                        parse_out.res0      = wait_res;
                        parse_out.res0.last = 1'b1;
                     end
                  end else begin
                     phase_in = (cmd_res.kind == KIND_LOOP) ? PH_IDLE : PH_ENDED;
                     parse_out.push0 = 1'b1;
                     if (pending) begin
                        parse_out.push1 = 1'b1;
                        parse_out.res0  = wait_res;
                        parse_out.res1  = cmd_res;
                     end else begin
                        parse_out.res0  = cmd_res;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_ENDED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         command_ff  <= '0;
         register_ff <= '0;
         wait_ff     <= '0;
         varint_ff   <= '0;
         shift_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         register_ff <= register_in;
         wait_ff     <= wait_in;
         varint_ff   <= varint_in;
         shift_ff    <= shift_in;
      end
   end

   a_end_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ENDED |=> phase_ff == PH_ENDED)
      else $error("parser left the ended phase");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      parse_out.push1 |-> parse_out.push0 && !parse_out.res0.last && parse_out.res1.last
                          && parse_out.res0.kind == KIND_WAIT)
      else $error("second result without a leading wait result");

   a_wait_cleared: assert property (@(posedge clock) disable iff (reset)
      parse_out.push0 && parse_out.res0.kind == KIND_WAIT |=> wait_ff == '0)
      else $error("wait total not cleared after it was reported");

endmodule

// ===== rtl/slcp_out_fifo.sv =====
// Result queue that takes up to two results per cycle and delivers one per pop.
module slcp_out_fifo (
   input  logic                                  clock,
   input  logic                                  reset,
   input  slcp_pkg::parse_out_type               parse_out,
   input  logic                                  pop,
   output slcp_pkg::result_type                  head,
   output logic                                  not_empty,
   output logic [$clog2(slcp_pkg::OUT_DEPTH):0]  count
);
   import slcp_pkg::*;

   localparam int PTR_W   = $clog2(OUT_DEPTH);
   localparam int COUNT_W = PTR_W + 1;

   result_type         entries_ff [OUT_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] push_count;
   logic               do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign push_count = COUNT_W'(parse_out.push0) + COUNT_W'(parse_out.push1);
   assign wr_ptr_in  = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in  = rd_ptr_ff + PTR_W'(do_pop);
   assign count_in   = count_ff + push_count - COUNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (parse_out.push0) begin
         entries_ff[wr_ptr_ff] <= parse_out.res0;
      end
      if (parse_out.push1) begin
         entries_ff[wr_ptr_ff + PTR_W'(1)] <= parse_out.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff + push_count) <= (COUNT_W'(OUT_DEPTH) + COUNT_W'(do_pop)))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(OUT_DEPTH))
      else $error("result queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PTR_W'(wr_ptr_ff - rd_ptr_ff) == PTR_W'(count_ff))
      else $error("result queue pointers disagree with count");

endmodule

// ===== rtl/sound_log_command_parser.sv =====
// Sound-log command parser top level: input register, configuration, parser and result queue.
// A byte accepted into the input register drives the parser from there; its results are
// written into the queue as the parser state updates and are then offered at the queue head.
// Throughput: one byte per cycle while req_ready is high; a byte's results leave one per pop. req_ready
// drops unless the eight-entry queue has room for two results beyond the held byte's two.
// Reset (synchronous, active high) clears the parser to idle, empties the queue and sets the
// enable mask to slot 0 only with no loop point.
module sound_log_command_parser #(
   parameter int DEVICE_SLOTS = slcp_pkg::DEVICE_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_stream_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_kind,
   output logic [slcp_pkg::SLOT_W-1:0]      rsp_device_slot,
   output logic [slcp_pkg::ADDR_W-1:0]      rsp_reg_address,
   output logic [7:0]                       rsp_reg_data,
   output logic [slcp_pkg::WAIT_W-1:0]      rsp_wait_syncs,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slcp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slcp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import slcp_pkg::*;

   localparam int COUNT_W = $clog2(OUT_DEPTH) + 1;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               loop_ff, loop_in;
   parse_out_type      parse_out;
   result_type         head;
   logic [COUNT_W-1:0] count;
   logic [COUNT_W:0]   committed;

   // Room is reserved for the byte in the input register and for the new one.
   assign committed = {1'b0, count} + (in_valid_ff ? (COUNT_W + 1)'(2) : '0);
   assign req_ready = committed <= (COUNT_W + 1)'(OUT_DEPTH - 2);
   assign csr_ready = 1'b1;

   assign in_valid_in = req_valid && req_ready;
   assign in_byte_in  = req_stream_byte;

   always_comb begin
      mask_in = mask_ff;
      loop_in = loop_ff;
      if (csr_valid) begin
         if (csr_index == CSR_DEVICE_ENABLE) begin
            mask_in = csr_data[MASK_W-1:0];
         end else if (csr_index == CSR_LOOP_PRESENT) begin
            loop_in = csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mask_ff     <= MASK_W'(1);
         loop_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         mask_ff     <= mask_in;
         loop_ff     <= loop_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   slcp_parser #(
      .DEVICE_SLOTS(DEVICE_SLOTS)
   ) u_parser (
      .clock              (clock),
      .reset              (reset),
      .byte_valid         (in_valid_ff),
      .stream_byte        (in_byte_ff),
      .device_enable_mask (mask_ff),
      .loop_present       (loop_ff),
      .parse_out          (parse_out)
   );

   slcp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .parse_out (parse_out),
      .pop       (rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .count     (count)
   );

   assign rsp_kind        = head.kind;
   assign rsp_device_slot = head.device_slot;
   assign rsp_reg_address = head.reg_address;
   assign rsp_reg_data    = head.reg_data;
   assign rsp_wait_syncs  = head.wait_syncs;
   assign rsp_last        = head.last;

endmodule

// ===== test/sound_log_command_parser_tb.sv =====
// Self-checking testbench for the sound-log command parser: directed and random bytes checked by a tracker.
`timescale 1ns / 100ps

module sound_log_command_parser_tb;
   import slcp_pkg::*;

   localparam int SLOTS_IN_USE = DEVICE_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP = 4'hF;

   // Tracks the parser state and holds the events the block still owes.
   class command_stream_tracker;
      typedef enum logic [2:0] {
         PH_IDLE, PH_REG, PH_DATA, PH_VARINT, PH_WAITING, PH_ENDED
      } phase_type;

      phase_type          phase = PH_IDLE;
      logic [7:0]         cmd_byte = '0;
      logic [7:0]         reg_byte = '0;
      logic [WAIT_W-1:0]  wait_sum = '0;
      logic [31:0]        vint = '0;
      logic [5:0]         vshift = '0;
      logic [MASK_W-1:0]  enable_mask = 16'h0001;
      bit                 loop_on = 1'b0;
      int                 mismatches = 0;
      result_type         owed_events[$];

      function int outstanding();
         return owed_events.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_DEVICE_ENABLE) begin
            enable_mask = data[MASK_W-1:0];
         end else if (index == CSR_LOOP_PRESENT) begin
            loop_on = data[0];
         end
      endfunction

      function void push_event(logic [1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [ADDR_W-1:0] addr, logic [7:0] data,
                               logic [WAIT_W-1:0] syncs, logic last);
         result_type ev;
         ev.kind = kind;
         ev.device_slot = slot;
         ev.reg_address = addr;
         ev.reg_data = data;
         ev.wait_syncs = syncs;
         ev.last = last;
         owed_events.push_back(ev);
      endfunction

      function void parse_byte(logic [7:0] b);
         logic [SLOT_W-1:0] slot;
         logic [63:0] group;
         case (phase)
            PH_ENDED: begin
               return;
            end
            PH_REG: begin
               reg_byte = b;
               phase = PH_DATA;
               return;
            end
            PH_DATA: begin
               slot = cmd_byte[6:1];
               phase = PH_IDLE;
               if (slot < 16 && slot < SLOTS_IN_USE) begin
                  if (enable_mask[slot[3:0]]) begin
                     push_event(KIND_WRITE, slot, {cmd_byte[0], reg_byte}, b, '0, 1'b1);
                  end
               end
               return;
            end
            PH_VARINT: begin
               // Groups landing at bit 32 or above are dropped; the shift stops at 35.
               if (vshift < 32) begin
                  group = 64'(b[6:0]) << vshift;
                  vint |= group[31:0];
               end
               if (vshift < 35) vshift += 6'd7;
               if (!b[7]) begin
                  wait_sum += vint + 32'd2;
                  phase = PH_WAITING;
               end
               return;
            end
            default: ;
         endcase

         if (b == BYTE_WAIT_SYNC) begin
            wait_sum += 32'd1;
            phase = PH_WAITING;
            return;
         end
         if (b == BYTE_WAIT_VARINT) begin
            vint = '0;
            vshift = '0;
            phase = PH_VARINT;
            return;
         end

         // A pending wait is flushed first; it is the last event only for a write command.
         if (phase == PH_WAITING) begin
            push_event(KIND_WAIT, '0, '0, '0, wait_sum, !b[7]);
            wait_sum = '0;
         end

         if (!b[7]) begin
            cmd_byte = b;
            phase = PH_REG;
         end else if (b == BYTE_LOOP && loop_on) begin
            push_event(KIND_LOOP, '0, '0, '0, '0, 1'b1);
            phase = PH_IDLE;
         end else begin
            push_event(KIND_END, '0, '0, '0, '0, 1'b1);
            phase = PH_ENDED;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void match_event(result_type got);
         result_type want;
         if (owed_events.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, actual kind %0d slot %0d addr %h data %h wait %h last %b",
                     $time, got.kind, got.device_slot, got.reg_address, got.reg_data,
                     got.wait_syncs, got.last);
            return;
         end
         want = owed_events.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("device_slot", want.device_slot, got.device_slot);
         compare_field("reg_address", want.reg_address, got.reg_address);
         compare_field("reg_data", want.reg_data, got.reg_data);
         compare_field("wait_syncs", want.wait_syncs, got.wait_syncs);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_stream_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_kind;
   logic [SLOT_W-1:0]       rsp_device_slot;
   logic [ADDR_W-1:0]       rsp_reg_address;
   logic [7:0]              rsp_reg_data;
   logic [WAIT_W-1:0]       rsp_wait_syncs;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   command_stream_tracker tracker;
   int cycle_count = 0;
   int bytes_sent = 0;
   int calm_sends = 0;
   int stall_left = 0;
   int calm_left = 0;
   int ready_roll;

   sound_log_command_parser #(.DEVICE_SLOTS(SLOTS_IN_USE)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_device_slot (rsp_device_slot),
      .rsp_reg_address (rsp_reg_address),
      .rsp_reg_data    (rsp_reg_data),
      .rsp_wait_syncs  (rsp_wait_syncs),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sound_log_command_parser test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.match_event({rsp_kind, rsp_device_slot, rsp_reg_address, rsp_reg_data,
                              rsp_wait_syncs, rsp_last});
      end
   end

   // Receiver back-pressure: short stalls, occasional long ones, and calm stretches.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 25) stall_left = $urandom_range(1, 3);
            else if (ready_roll < 29) stall_left = $urandom_range(10, 40);
            else if (ready_roll < 31) calm_left = $urandom_range(50, 300);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm_sends > 0) begin
         calm_sends--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(8, 30);
      calm_sends = $urandom_range(30, 150);
      return 0;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_stream_byte <= b;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.parse_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_write(input logic [7:0] cmd, input logic [7:0] addr_lo,
                             input logic [7:0] data);
      send_byte(cmd);
      send_byte(addr_lo);
      send_byte(data);
   endtask

   // Encodes value in 7-bit groups; extra groups carry value bits up to bit 31, random bits beyond.
   task automatic send_varint_wait(input logic [31:0] value, input int extra);
      int groups;
      logic [6:0] grp;
      send_byte(BYTE_WAIT_VARINT);
      groups = 1;
      while (groups < 5 && (value >> (7 * groups)) != 0) groups++;
      groups += extra;
      for (int i = 0; i < groups; i++) begin
         if (i < 4) grp = value[7*i +: 7];
         else if (i == 4) grp = {3'($urandom), value[31:28]};
         else grp = 7'($urandom);
         send_byte({i != groups - 1, grp});
      end
   endtask

   task automatic send_random_command();
      int pick;
      logic [31:0] count;
      pick = $urandom_range(0, 99);
      if (pick < 52 || (pick >= 88 && !tracker.loop_on)) begin
         if ($urandom_range(0, 1) == 1) begin
            send_write(8'($urandom_range(0, 31)), 8'($urandom), 8'($urandom));
         end else begin
            send_write(8'($urandom_range(0, 127)), 8'($urandom), 8'($urandom));
         end
      end else if (pick < 70) begin
         send_byte(BYTE_WAIT_SYNC);
      end else if (pick < 88) begin
         count = $urandom >> $urandom_range(0, 31);
         send_varint_wait(count, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      end else begin
         send_byte(BYTE_LOOP);
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_command();
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(index, data);
      @(negedge clock);
   endtask

   // The sender stops and the block drains completely before the registers change.
   task automatic reconfigure(input logic [MASK_W-1:0] mask,
                              input logic [CSR_DATA_W-1:0] loop_word, input bit poke_unused);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write(CSR_DEVICE_ENABLE, mask);
      csr_write(CSR_LOOP_PRESENT, loop_word);
      if (poke_unused) begin
         csr_write(CSR_UNUSED_TOP, 16'($urandom));
         csr_write(4'($urandom_range(2, 14)), 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: only slot 0 enabled, no loop point.
      send_write(8'h00, 8'h00, 8'hFF);
      send_write(8'h02, 8'h12, 8'h34);
      send_write(8'h7F, 8'hAA, 8'h55);
      // This wait run wraps to zero and uses an over-long varint.
      send_byte(BYTE_WAIT_SYNC);
      send_varint_wait(32'hFFFF_FFFD, 2);
      send_write(8'h01, 8'hFF, 8'h00);

      reconfigure(16'hFFFF, 16'h0001, 1'b0);
      send_byte(BYTE_WAIT_SYNC);
      send_byte(BYTE_LOOP);
      send_byte(BYTE_LOOP);
      send_write(8'h1F, 8'h80, 8'h01);
      send_write(8'h20, 8'h00, 8'h00);
      run_random(290);

      reconfigure(16'h0000, 16'hFFFE, 1'b1);
      run_random(300);
      reconfigure(16'($urandom), 16'($urandom), 1'b1);
      run_random(300);
      reconfigure(16'h8000, 16'h0001, 1'b0);
      run_random(300);
      reconfigure(16'($urandom), 16'($urandom), 1'b0);
      run_random(300);
      reconfigure(16'hFFFF, 16'h0000, 1'b0);
      run_random(300);

      // End of playback, then bytes that must all be ignored.
      send_byte(BYTE_WAIT_SYNC);
      if (!tracker.loop_on && $urandom_range(0, 1) == 1) send_byte(BYTE_LOOP);
      else send_byte(8'($urandom_range(8'h80, 8'hFC)));
      send_byte(BYTE_WAIT_SYNC);
      send_byte(BYTE_WAIT_VARINT);
      send_byte(8'h00);
      send_byte(BYTE_LOOP);
      repeat (4) send_byte(8'($urandom));

      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("sound_log_command_parser test passed");
      end else begin
         $display("sound_log_command_parser test failed");
      end
      $finish;
   end

endmodule
